// ----- rtl/core/assert_macros.svh -----
// assertion macros for the rtl files of the edge generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define AST_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pa_edge_pkg.sv -----
// types and constants of the preferential attachment edge generator
`default_nettype none

package pa_edge_pkg;

    localparam int WORD_W     = 16;
    localparam int DIV_W      = 17;
    localparam int STEP_CNT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int NODE_CFG_W = 9;
    localparam int LINK_CFG_W = 4;
    localparam int NODE_OUT_W = 8;
    localparam int WEIGHT_W   = 7;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam int WEIGHT_MOD = 100;
    localparam int MIN_NODES  = 2;
    localparam int MIN_LINKS  = 1;

    // floor(2^22 / 100): quotient estimate is exact or one low for 16-bit words
    localparam int WEIGHT_RECIP = 41943;
    localparam int RECIP_SHIFT  = 22;
    localparam int WQ_W         = 10;
    localparam int WR_W         = 8;

    localparam logic [NODE_CFG_W-1:0] NODE_COUNT_RST = 9'd256;
    localparam logic [LINK_CFG_W-1:0] LINKS_RST      = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODE_COUNT     = 2'd0,
        REG_LINKS_PER_NODE = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_PK,
        ST_LIST_RD,
        ST_LIST_CHK,
        ST_MAP_RD,
        ST_MAP_CHK,
        ST_APP_TGT,
        ST_APP_NEW,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/preferential_attachment_edge_gen_unit.sv -----
// preferential attachment edge generator: sequencer, shared divider, link map and endpoint list
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   s_tdata  = pick_random, weight_random
//  m_*       out  m_tvalid/m_tready   m_tdata  = from_node, to_node, edge_weight; m_tlast
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
//  an attempt that makes an edge runs, from the accept to the next ready, through the accept,
//  16 steps of the one restoring divider (pick mod node count or endpoint count, weight mod 100
//  folded by a reciprocal multiply meanwhile), list read and check, map row read and
//  check-write, two list appends and the output load; a seed edge skips the list read and
//  check; a zero seed pick ends after the divider, a self pick after the list check, and an
//  already linked pick after the map check; after reset a clearing pass zeroes the link map,
//  one row a cycle, all MAX_NODES rows, during which no word is accepted; config writes are taken at any time
//  one result waits in the output register; while it is held the next attempt stalls in its last state
`default_nettype none
`include "assert_macros.svh"

module preferential_attachment_edge_gen_unit #(
    parameter int MAX_NODES  = 256,
    parameter int MAX_LINKS  = 8,
    parameter int LIST_DEPTH = 4096
) (
    input  wire  logic                               clk,
    input  wire  logic                               rst_n,
    // pick_random [15:0], weight_random [31:16]
    input  wire  logic [pa_edge_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire  logic                               s_tvalid,
    output logic                                     s_tready,
    // from_node [7:0], to_node [15:8], edge_weight [22:16], zero [23]
    output logic [pa_edge_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                     m_tlast,
    output logic                                     m_tvalid,
    input  wire  logic                               m_tready,
    input  wire  logic                               cfg_valid,
    output logic                                     cfg_ready,
    input  wire  logic [pa_edge_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  logic [pa_edge_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pa_edge_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int LW = $clog2(MAX_LINKS + 1);
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int TW = $clog2(LIST_DEPTH + 1);

    state_t                  state_reg, state_next;
    logic [NODE_CFG_W-1:0]   node_count_reg, node_count_next;
    logic [LINK_CFG_W-1:0]   links_reg, links_next;
    logic [TW-1:0]           total_reg, total_next;
    logic [CW-1:0]           cur_reg, cur_next;
    logic [LW-1:0]           link_reg, link_next;
    logic                    seeded_reg, seeded_next;
    logic [NW-1:0]           clr_reg, clr_next;
    logic [STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    logic [WORD_W-1:0]       wrand_reg, wrand_next;
    logic [WQ_W-1:0]         wq_reg, wq_next;
    logic [WR_W-1:0]         wr_reg, wr_next;
    logic [WORD_W-1:0]       dq_reg, dq_next;
    logic [DIV_W-1:0]        rem_reg, rem_next;
    logic [DIV_W-1:0]        div_d_reg, div_d_next;
    logic [WEIGHT_W-1:0]     weight_reg, weight_next;
    logic [NW-1:0]           target_reg, target_next;
    logic [NODE_OUT_W-1:0]   out_from_reg, out_from_next;
    logic [NODE_OUT_W-1:0]   out_to_reg, out_to_next;
    logic [WEIGHT_W-1:0]     out_wt_reg, out_wt_next;
    logic                    out_last_reg, out_last_next;

    logic [MAX_NODES-1:0]    map_mem [MAX_NODES];
    logic [NW-1:0]           list_mem [LIST_DEPTH];
    logic [MAX_NODES-1:0]    map_rd_reg;
    logic [NW-1:0]           list_rd_reg;

    logic                    map_we, map_re;
    logic [NW-1:0]           map_waddr, map_raddr;
    logic [MAX_NODES-1:0]    map_wdata;
    logic                    list_we, list_re;
    logic [AW-1:0]           list_waddr, list_raddr;
    logic [NW-1:0]           list_wdata;

    logic [CW-1:0]           n_eff;
    logic [LW-1:0]           links_eff;
    logic [NW-1:0]           new_node;
    logic [NW-1:0]           row_idx, bit_idx;
    logic                    graph_done;
    logic                    list_room;
    logic [DIV_W-1:0]        trial;
    logic [DIV_W-1:0]        step_rem;
    logic [LW:0]             link_inc;
    logic [CW-1:0]           cur_inc;
    logic [2*WORD_W-1:0]     w_prod;
    logic [WORD_W-1:0]       w_back;
    logic [WORD_W-1:0]       w_diff;
    logic [WR_W-1:0]         w_fold;

    // clamp of the config registers into their legal ranges
    always_comb
    begin
        logic [31:0] nc;
        logic [31:0] lk;
        nc = 32'(node_count_reg);
        lk = 32'(links_reg);
        if (nc < 32'(MIN_NODES))
            nc = 32'(MIN_NODES);
        if (nc > 32'(MAX_NODES))
            nc = 32'(MAX_NODES);
        if (lk < 32'(MIN_LINKS))
            lk = 32'(MIN_LINKS);
        if (lk > 32'(MAX_LINKS))
            lk = 32'(MAX_LINKS);
        n_eff     = CW'(nc);
        links_eff = LW'(lk);
    end

    assign new_node   = seeded_reg ? cur_reg[NW-1:0] : '0;
    assign row_idx    = (target_reg > new_node) ? target_reg : new_node;
    assign bit_idx    = (target_reg > new_node) ? new_node : target_reg;
    assign graph_done = seeded_reg && ((cur_reg >= n_eff) || (total_reg == '0));
    assign list_room  = total_reg < TW'(LIST_DEPTH);

    // one restoring division step
    assign trial    = {rem_reg[DIV_W-2:0], dq_reg[WORD_W-1]};
    assign step_rem = (trial >= div_d_reg) ? (trial - div_d_reg) : trial;

    // weight word mod 100: quotient estimate, remainder 0..199, one fold
    assign w_prod = (2*WORD_W)'(wrand_reg) * (2*WORD_W)'(WEIGHT_RECIP);
    assign w_back = WORD_W'(wq_reg) * WORD_W'(WEIGHT_MOD);
    assign w_diff = wrand_reg - w_back;
    assign w_fold = (wr_reg >= WR_W'(WEIGHT_MOD)) ? (wr_reg - WR_W'(WEIGHT_MOD)) : wr_reg;

    assign link_inc = {1'b0, link_reg} + (LW + 1)'(1);
    assign cur_inc  = cur_reg + CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        links_next      = links_reg;
        total_next      = total_reg;
        cur_next        = cur_reg;
        link_next       = link_reg;
        seeded_next     = seeded_reg;
        clr_next        = clr_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        wrand_next      = wrand_reg;
        wq_next         = wq_reg;
        wr_next         = wr_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        div_d_next      = div_d_reg;
        weight_next     = weight_reg;
        target_next     = target_reg;
        out_from_next   = out_from_reg;
        out_to_next     = out_to_reg;
        out_wt_next     = out_wt_reg;
        out_last_next   = out_last_reg;
        map_we          = 1'b0;
        map_re          = 1'b0;
        map_waddr       = row_idx;
        map_raddr       = row_idx;
        map_wdata       = map_rd_reg | (MAX_NODES'(1) << bit_idx);
        list_we         = 1'b0;
        list_re         = 1'b0;
        list_waddr      = total_reg[AW-1:0];
        list_raddr      = rem_reg[AW-1:0];
        list_wdata      = target_reg;

        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NODE_COUNT:     node_count_next = cfg_data[NODE_CFG_W-1:0];
                REG_LINKS_PER_NODE: links_next = cfg_data[LINK_CFG_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + NW'(1);
                if (clr_reg == NW'(MAX_NODES - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    wrand_next = s_tdata[2*WORD_W-1:WORD_W];
                    dq_next    = s_tdata[WORD_W-1:0];
                    rem_next   = '0;
                    cnt_next   = '0;
                    div_d_next = seeded_reg ? DIV_W'(total_reg) : DIV_W'(n_eff);
                    if (!graph_done)
                        state_next = ST_DIV_PK;
                end
            end
            ST_DIV_PK:
            begin
                rem_next = step_rem;
                dq_next  = dq_reg << 1;
                cnt_next = cnt_reg + STEP_CNT_W'(1);
                if (cnt_reg == STEP_CNT_W'(0))
                    wq_next = w_prod[RECIP_SHIFT+WQ_W-1:RECIP_SHIFT];
                if (cnt_reg == STEP_CNT_W'(1))
                    wr_next = w_diff[WR_W-1:0];
                if (cnt_reg == STEP_CNT_W'(2))
                    weight_next = WEIGHT_W'(w_fold) + WEIGHT_W'(1);
                if (cnt_reg == STEP_CNT_W'(WORD_W - 1))
                begin
                    if (seeded_reg)
                        state_next = ST_LIST_RD;
                    else if (step_rem == '0)
                        state_next = ST_IDLE;
                    else
                    begin
                        target_next = step_rem[NW-1:0];
                        state_next  = ST_MAP_RD;
                    end
                end
            end
            ST_LIST_RD:
            begin
                list_re    = 1'b1;
                state_next = ST_LIST_CHK;
            end
            ST_LIST_CHK:
            begin
                target_next = list_rd_reg;
                // a node never links to itself
                if (list_rd_reg == new_node)
                    state_next = ST_IDLE;
                else
                    state_next = ST_MAP_RD;
            end
            ST_MAP_RD:
            begin
                map_re     = 1'b1;
                state_next = ST_MAP_CHK;
            end
            ST_MAP_CHK:
            begin
                // the seed edge is never checked
                if (seeded_reg && map_rd_reg[bit_idx])
                    state_next = ST_IDLE;
                else
                begin
                    map_we     = 1'b1;
                    state_next = ST_APP_TGT;
                end
            end
            ST_APP_TGT:
            begin
                if (list_room)
                begin
                    list_we    = 1'b1;
                    total_next = total_reg + TW'(1);
                end
                state_next = ST_APP_NEW;
            end
            ST_APP_NEW:
            begin
                list_wdata = new_node;
                if (list_room)
                begin
                    list_we    = 1'b1;
                    total_next = total_reg + TW'(1);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_from_next  = NODE_OUT_W'(target_reg);
                    out_to_next    = NODE_OUT_W'(new_node);
                    out_wt_next    = weight_reg;
                    out_last_next  = 1'b0;
                    if (!seeded_reg)
                    begin
                        seeded_next = 1'b1;
                        cur_next    = CW'(1);
                        link_next   = '0;
                    end
                    else if (link_inc >= {1'b0, links_eff})
                    begin
                        link_next     = '0;
                        cur_next      = cur_inc;
                        out_last_next = cur_inc >= n_eff;
                    end
                    else
                        link_next = link_inc[LW-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            node_count_reg <= NODE_COUNT_RST;
            links_reg      <= LINKS_RST;
            total_reg      <= '0;
            cur_reg        <= '0;
            link_reg       <= '0;
            seeded_reg     <= 1'b0;
            clr_reg        <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            links_reg      <= links_next;
            total_reg      <= total_next;
            cur_reg        <= cur_next;
            link_reg       <= link_next;
            seeded_reg     <= seeded_next;
            clr_reg        <= clr_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wrand_reg    <= wrand_next;
        wq_reg       <= wq_next;
        wr_reg       <= wr_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        div_d_reg    <= div_d_next;
        weight_reg   <= weight_next;
        target_reg   <= target_next;
        out_from_reg <= out_from_next;
        out_to_reg   <= out_to_next;
        out_wt_reg   <= out_wt_next;
        out_last_reg <= out_last_next;
    end

    // link map: row is the larger node, bit the smaller one
    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        if (map_re)
            map_rd_reg <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_waddr] <= list_wdata;
        if (list_re)
            list_rd_reg <= list_mem[list_raddr];
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tlast   = out_last_reg;
    assign m_tdata   = {1'b0, out_wt_reg, out_to_reg, out_from_reg};

    `AST_IMPL(a_clear_blocks, state_reg == ST_CLEAR, !s_tready, "word accepted during map clear")
    `AST_IMPL(a_weight_range, m_tvalid, m_tdata[22:16] != 7'd0 && m_tdata[22:16] <= 7'd100,
        "edge weight out of range")
    `AST_NEXT(a_busy_after_accept, s_tvalid && s_tready && !graph_done, !s_tready,
        "ready again right after a live attempt")
    `AST_PROP(a_total_bound, total_reg <= TW'(LIST_DEPTH), "endpoint count past list depth")

endmodule

`default_nettype wire
